>>> sv/fsc_pkg.sv
package fsc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_FRAMES = 8;
  localparam int DEF_PIXEL_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int OP_W       = 2;
  localparam int FC_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd1;

  // Combine modes
  localparam logic [OP_W-1:0] OP_SUM    = 2'd0;
  localparam logic [OP_W-1:0] OP_MEAN   = 2'd1;
  localparam logic [OP_W-1:0] OP_MEDIAN = 2'd2;

  localparam logic [OP_W-1:0] OP_RESET = OP_SUM;
  localparam logic [FC_W-1:0] FC_RESET = 4'd8;

endpackage

>>> sv/fsc_stream_if.sv
// Input word: one pixel per frame at the same position
interface fsc_pix_if #(
  parameter int MAX_FRAMES = fsc_pkg::DEF_MAX_FRAMES,
  parameter int PIXEL_BITS = fsc_pkg::DEF_PIXEL_BITS
);
  logic                                  valid;
  logic                                  ready;
  logic [MAX_FRAMES-1:0][PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// Result word: one combined value
interface fsc_res_if #(
  parameter int VALUE_BITS = fsc_pkg::DEF_PIXEL_BITS + $clog2(fsc_pkg::DEF_MAX_FRAMES)
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] combined_value;

  modport source (output valid, output combined_value, input ready);
  modport sink   (input valid, input combined_value, output ready);
endinterface

>>> sv/frame_stack_combiner_unit.sv
// Channel  | Direction | Payload                                  | Handshake
// in_ch    | sink      | pixel[MAX_FRAMES] x PIXEL_BITS           | valid / ready
// out_ch   | source    | combined_value, PIXEL_BITS+clog2(MAX)    | valid / ready
// cfg_*    | write     | cfg_index selects operation/frame_count  | cfg_we, no wait
//
// One word per cycle sustained while out_ch.ready stays high; each word passes the
// stages in order (compare/partial sums, rank/total, median pick and reciprocal
// multiply, quotient, mean correction and output register).
// rst_n is synchronous and clears the stage valid bits and the config registers.
// A stage holds only when it is full and the stage after it cannot take its word,
// so bubbles close up and in_ch.ready stays high while any stage is empty.
module frame_stack_combiner_unit #(
  parameter int MAX_FRAMES = fsc_pkg::DEF_MAX_FRAMES,
  parameter int PIXEL_BITS = fsc_pkg::DEF_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fsc_pix_if.sink                        in_ch,
  fsc_res_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fsc_pkg::*;

  localparam int PW = PIXEL_BITS;
  localparam int SW = PIXEL_BITS + $clog2(MAX_FRAMES);
  localparam int RW = $clog2(MAX_FRAMES);
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int NG = (MAX_FRAMES + 3) / 4;
  localparam int GW = PW + 2;
  localparam int KL = SW / 2;
  localparam int KH = SW - KL;
  localparam int NS = 5;

  // ---------------------------------------------------------------- config
  logic [OP_W-1:0] op_r;
  logic [FC_W-1:0] fc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_RESET;
      fc_r <= FC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPERATION:   op_r <= cfg_data[OP_W-1:0];
        CFG_FRAME_COUNT: fc_r <= cfg_data[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the lane count to 2..MAX_FRAMES
  logic [FC_W:0]       fc_x;
  logic [NW-1:0]       n_c;
  logic [NW-1:0]       mid_c;
  logic [MAX_FRAMES-1:0] act_c;

  always_comb begin
    fc_x = {1'b0, fc_r};
    if (fc_x < (FC_W+1)'(2)) begin
      n_c = NW'(2);
    end else if (fc_x > (FC_W+1)'(MAX_FRAMES)) begin
      n_c = NW'(MAX_FRAMES);
    end else begin
      n_c = fc_x[NW-1:0];
    end
    mid_c = (n_c - NW'(1)) >> 1;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      act_c[i] = (NW'(i) < n_c);
    end
  end

  // floor(2^SW / n) for each lane count n of 2 or more; zero for 0 and 1
  logic [SW-1:0] recip_tab [MAX_FRAMES+1];
  for (genvar g = 0; g <= MAX_FRAMES; g++) begin : g_recip
    localparam longint unsigned RV = (g < 2) ? 0 : ((64'd1 << SW) / ((g < 2) ? 1 : g));
    assign recip_tab[g] = SW'(RV);
  end

  // ---------------------------------------------------------------- handshake
  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_ch.valid;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  assign in_ch.ready = adv[0];

  // ---------------------------------------------------------------- stage A
  // Lane j is "before" lane i when smaller, or equal with a lower index.
  logic [PW-1:0]         a_pix_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] a_bef_r [MAX_FRAMES];
  logic [GW-1:0]         a_gsum_r [NG];
  logic [MAX_FRAMES-1:0] a_bef_nxt [MAX_FRAMES];
  logic [GW-1:0]         a_gsum_nxt [NG];

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        a_bef_nxt[i][j] = act_c[j] && (j != i) &&
                          ((in_ch.pixel[j] < in_ch.pixel[i]) ||
                           ((in_ch.pixel[j] == in_ch.pixel[i]) && (j < i)));
      end
    end
    for (int g = 0; g < NG; g++) begin
      a_gsum_nxt[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if ((g * 4 + k) < MAX_FRAMES) begin
          if (act_c[g*4+k]) begin
            a_gsum_nxt[g] = a_gsum_nxt[g] + GW'(in_ch.pixel[g*4+k]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        a_pix_r[i] <= in_ch.pixel[i];
        a_bef_r[i] <= a_bef_nxt[i];
      end
      for (int g = 0; g < NG; g++) begin
        a_gsum_r[g] <= a_gsum_nxt[g];
      end
    end
  end

  // ---------------------------------------------------------------- stage B
  logic [PW-1:0]  b_pix_r [MAX_FRAMES];
  logic [RW-1:0]  b_rank_r [MAX_FRAMES];
  logic [SW-1:0]  b_sum_r;
  logic [GW+1:0]  b_sum_nxt;

  always_comb begin
    b_sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      b_sum_nxt = b_sum_nxt + (GW+2)'(a_gsum_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        b_pix_r[i]  <= a_pix_r[i];
        b_rank_r[i] <= RW'($countones(a_bef_r[i]));
      end
      b_sum_r <= b_sum_nxt[SW-1:0];
    end
  end

  // ---------------------------------------------------------------- stage C
  // Pick the lane whose rank is the lower middle; start sum * (2^SW / n).
  logic [MAX_FRAMES-1:0] med_hit;
  logic [PW-1:0]         med_nxt;
  logic [SW-1:0]         recip_c;
  logic [PW-1:0]         c_med_r;
  logic [SW-1:0]         c_sum_r;
  logic [SW+KL-1:0]      c_plo_r;
  logic [SW+KH-1:0]      c_phi_r;

  always_comb begin
    med_nxt = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      med_hit[i] = act_c[i] && (NW'(b_rank_r[i]) == mid_c);
      if (med_hit[i]) med_nxt = med_nxt | b_pix_r[i];
    end
    recip_c = recip_tab[n_c];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      c_med_r <= med_nxt;
      c_sum_r <= b_sum_r;
      c_plo_r <= (SW+KL)'(b_sum_r) * (SW+KL)'(recip_c[KL-1:0]);
      c_phi_r <= (SW+KH)'(b_sum_r) * (SW+KH)'(recip_c[SW-1:KL]);
    end
  end

  // ---------------------------------------------------------------- stage D
  logic [2*SW-1:0] prod_c;
  logic [PW-1:0]   d_med_r;
  logic [SW-1:0]   d_sum_r;
  logic [SW-1:0]   d_q_r;

  assign prod_c = {c_phi_r, {KL{1'b0}}} + (2*SW)'(c_plo_r);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_med_r <= c_med_r;
      d_sum_r <= c_sum_r;
      d_q_r   <= prod_c[2*SW-1:SW];
    end
  end

  // ---------------------------------------------------------------- stage E
  // The estimate is at most one short: add one when the remainder reaches n.
  logic [SW+NW-1:0] qn_c;
  logic [SW-1:0]    rem_c;
  logic [SW-1:0]    n_ext;
  logic [SW-1:0]    mean_c;
  logic [SW-1:0]    out_nxt;
  logic [SW-1:0]    out_value_r;

  always_comb begin
    qn_c   = (SW+NW)'(d_q_r) * (SW+NW)'(n_c);
    rem_c  = d_sum_r - qn_c[SW-1:0];
    n_ext  = SW'(n_c);
    mean_c = (rem_c >= n_ext) ? d_q_r + SW'(1) : d_q_r;
    case (op_r)
      OP_SUM:    out_nxt = d_sum_r;
      OP_MEAN:   out_nxt = mean_c;
      OP_MEDIAN: out_nxt = SW'(d_med_r);
      default:   out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_value_r <= out_nxt;
    end
  end

  assign out_ch.valid          = v_r[NS-1];
  assign out_ch.combined_value = out_value_r;

  // ---------------------------------------------------------------- checks
  a_median_unique: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> $onehot(med_hit))
    else $error("median rank does not select exactly one lane");

  a_mean_estimate: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (rem_c < (n_ext << 1)))
    else $error("reciprocal quotient off by more than one");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled while a pipeline stage is empty");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !v_r[NS-2] |=> !out_ch.valid)
    else $error("output word repeated");

endmodule
